@@ rtl/lcr_pkg.sv @@
package lcr_pkg;

  localparam int unsigned COUNT_W          = 24;
  localparam int unsigned DIFF_W           = COUNT_W + 1;
  localparam int unsigned SCALE_W          = 32;
  localparam int unsigned WEIGHT_W         = 32;
  localparam int unsigned PROD_W           = DIFF_W + SCALE_W;
  localparam int unsigned FRAC_SHIFT       = 16;
  localparam int unsigned QUEUE_DEPTH      = 2;
  localparam int unsigned SAMPLE_BITS_DEF  = 24;
  localparam int unsigned EXTRA_PULSES_DEF = 1;

  localparam logic [SCALE_W-1:0]        SCALE_RESET = 32'd7550;
  localparam logic signed [COUNT_W-1:0] COUNT_MAX   = 24'sh7FFFFF;
  localparam logic signed [COUNT_W-1:0] COUNT_MIN   = 24'sh800000;
  localparam logic [PROD_W:0]           ROUND_BIAS  = (PROD_W + 1)'(32'h8000);
  localparam logic [WEIGHT_W-1:0]       WEIGHT_MAX  = 32'h7FFF_FFFF;
  localparam logic [WEIGHT_W-1:0]       WEIGHT_MIN  = 32'h8000_0000;

  typedef struct packed {
    logic data_pin;
    logic sample_request;
    logic tare_request;
  } in_word_t;

  typedef struct packed {
    logic                        clock_pin;
    logic                        busy_res;
    logic                        weight_valid;
    logic signed [WEIGHT_W-1:0]  weight_q8;
    logic signed [COUNT_W-1:0]   raw_count;
    logic signed [COUNT_W-1:0]   tare_count;
  } out_word_t;

  typedef struct packed {
    logic                       clock_pin;
    logic                       busy_res;
    logic                       weight_valid;
    logic signed [DIFF_W-1:0]   diff;
    logic signed [COUNT_W-1:0]  raw_count;
    logic signed [COUNT_W-1:0]  tare_count;
  } tick_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

@@ rtl/load_cell_reader_tare_scale_top.sv @@
// Load cell reader with tare and scale. Each input word is one half-clock tick
// of the converter's serial link and yields exactly one output word carrying
// the clock level for that tick, busy and weight flags, the weight in grams
// (signed Q24.8, rounded and saturated), the last raw count and the tare.
// A sample request with data low starts a read of SAMPLE_BITS pulses plus
// EXTRA_PULSES gain pulses; with data high the last count is weighed at once.
// The block takes one input word per cycle while the queue is not full. An
// input word is written into a queue slot, then registered in the multiply
// stage (count difference times scale) and in the rounding and saturation
// output register before it leaves. A two-word queue between the sequencer
// and the arithmetic lets either side stall. The scale register is written on
// its own valid/ready port, always ready, and must change only while no word
// is in flight.
module load_cell_reader_tare_scale_top #(
  parameter int unsigned SAMPLE_BITS  = lcr_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned EXTRA_PULSES = lcr_pkg::EXTRA_PULSES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  lcr_pkg::in_word_t           in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output lcr_pkg::out_word_t          out_data_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [lcr_pkg::SCALE_W-1:0] cfg_data_i
);

  logic                          accept;
  logic                          pop;
  logic [lcr_pkg::SCALE_W-1:0]   scale_q;
  lcr_pkg::tick_t                front_rec;
  lcr_pkg::tick_t                queue_rec;
  lcr_pkg::queue_status_t        q_status;

  assign in_stall_o  = q_status.full;
  assign accept      = in_valid_i && !q_status.full;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= lcr_pkg::SCALE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      scale_q <= cfg_data_i;
    end
  end

  lcr_front #(
    .SAMPLE_BITS  (SAMPLE_BITS),
    .EXTRA_PULSES (EXTRA_PULSES)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .in_i     (in_data_i),
    .rec_o    (front_rec)
  );

  lcr_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (accept),
    .rec_i    (front_rec),
    .pop_i    (pop),
    .rec_o    (queue_rec),
    .status_o (q_status)
  );

  lcr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .scale_i     (scale_q),
    .rec_i       (queue_rec),
    .rec_avail_i (!q_status.empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

`ifndef SYNTHESIS
  a_no_weight_without_flag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.weight_valid |-> out_data_o.weight_q8 == '0)
    else $error("weight present without weight_valid");

  a_pop_not_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_status.empty)
    else $error("queue popped while empty");

  a_clock_only_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && front_rec.clock_pin |-> front_rec.busy_res)
    else $error("serial clock driven outside a read");

  a_full_blocks_push : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_status.full && !pop |=> q_status.full)
    else $error("queue lost a word while full");
`endif

endmodule

@@ rtl/lcr_front.sv @@
module lcr_front #(
  parameter int unsigned SAMPLE_BITS  = lcr_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned EXTRA_PULSES = lcr_pkg::EXTRA_PULSES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  lcr_pkg::in_word_t in_i,
  output lcr_pkg::tick_t   rec_o
);

  localparam int unsigned CNT_W = $clog2(SAMPLE_BITS);
  localparam int unsigned EXT_W = (SAMPLE_BITS > lcr_pkg::COUNT_W) ? SAMPLE_BITS
                                                                    : lcr_pkg::COUNT_W;
  localparam logic [CNT_W-1:0] DATA_LAST  = CNT_W'(SAMPLE_BITS - 1);
  localparam logic [CNT_W-1:0] EXTRA_LAST = CNT_W'(EXTRA_PULSES - 1);
  localparam logic signed [EXT_W-1:0] SAT_HI = EXT_W'(lcr_pkg::COUNT_MAX);
  localparam logic signed [EXT_W-1:0] SAT_LO = EXT_W'(lcr_pkg::COUNT_MIN);

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_DATA  = 2'd1;
  localparam logic [1:0] PH_EXTRA = 2'd2;

  logic [1:0]                        phase_q, phase_d;
  logic [CNT_W-1:0]                  cnt_q, cnt_d;
  logic                              clk_lvl_q, clk_lvl_d;
  logic [SAMPLE_BITS-1:0]            shift_q, shift_d;
  logic signed [lcr_pkg::COUNT_W-1:0] last_q, last_d;
  logic signed [lcr_pkg::COUNT_W-1:0] tare_q, tare_d;
  logic signed [EXT_W-1:0]           ext;
  logic signed [lcr_pkg::COUNT_W-1:0] finished;
  logic                              clk_out, busy, valid;

  always_comb begin
    ext = EXT_W'($signed(shift_q));
    if (ext > SAT_HI) begin
      finished = lcr_pkg::COUNT_MAX;
    end else if (ext < SAT_LO) begin
      finished = lcr_pkg::COUNT_MIN;
    end else begin
      finished = ext[lcr_pkg::COUNT_W-1:0];
    end
  end

  always_comb begin
    phase_d   = phase_q;
    cnt_d     = cnt_q;
    clk_lvl_d = clk_lvl_q;
    shift_d   = shift_q;
    last_d    = last_q;
    clk_out   = 1'b0;
    busy      = 1'b0;
    valid     = 1'b0;
    case (phase_q)
      PH_DATA, PH_EXTRA: begin
        busy = 1'b1;
        if (!clk_lvl_q) begin
          clk_out   = 1'b1;
          clk_lvl_d = 1'b1;
          if (phase_q == PH_DATA) begin
            shift_d = {shift_q[SAMPLE_BITS-2:0], in_i.data_pin};
          end
        end else begin
          clk_lvl_d = 1'b0;
          cnt_d     = cnt_q + 1'b1;
          if (phase_q == PH_DATA) begin
            if (cnt_q == DATA_LAST) begin
              phase_d = PH_EXTRA;
              cnt_d   = '0;
            end
          end else if (cnt_q == EXTRA_LAST) begin
            last_d  = finished;
            phase_d = PH_IDLE;
            cnt_d   = '0;
            valid   = 1'b1;
          end
        end
      end
      default: begin
        phase_d   = PH_IDLE;
        clk_lvl_d = 1'b0;
        if (in_i.sample_request) begin
          if (!in_i.data_pin) begin
            phase_d = PH_DATA;
            cnt_d   = '0;
            shift_d = '0;
            busy    = 1'b1;
          end else begin
            valid = 1'b1;
          end
        end
      end
    endcase
    tare_d = in_i.tare_request ? last_q : tare_q;
  end

  always_comb begin
    rec_o.clock_pin    = clk_out;
    rec_o.busy_res     = busy;
    rec_o.weight_valid = valid;
    rec_o.diff         = lcr_pkg::DIFF_W'(last_d) - lcr_pkg::DIFF_W'(tare_d);
    rec_o.raw_count    = last_d;
    rec_o.tare_count   = tare_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      cnt_q     <= '0;
      clk_lvl_q <= 1'b0;
      shift_q   <= '0;
      last_q    <= '0;
      tare_q    <= '0;
    end else if (accept_i) begin
      phase_q   <= phase_d;
      cnt_q     <= cnt_d;
      clk_lvl_q <= clk_lvl_d;
      shift_q   <= shift_d;
      last_q    <= last_d;
      tare_q    <= tare_d;
    end
  end

endmodule

@@ rtl/lcr_queue.sv @@
module lcr_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  lcr_pkg::tick_t         rec_i,
  input  logic                   pop_i,
  output lcr_pkg::tick_t         rec_o,
  output lcr_pkg::queue_status_t status_o
);

  localparam int unsigned PTR_W = $clog2(lcr_pkg::QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(lcr_pkg::QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(lcr_pkg::QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(lcr_pkg::QUEUE_DEPTH);

  lcr_pkg::tick_t   slots_q [lcr_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;

  assign rec_o          = slots_q[rd_q];
  assign status_o.full  = (cnt_q == FULL_CNT);
  assign status_o.empty = (cnt_q == '0);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_q] <= rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == LAST_SLOT) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == LAST_SLOT) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

@@ rtl/lcr_back.sv @@
module lcr_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [lcr_pkg::SCALE_W-1:0]   scale_i,
  input  lcr_pkg::tick_t                rec_i,
  input  logic                          rec_avail_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output lcr_pkg::out_word_t            out_data_o
);

  logic                                s1_valid_q;
  logic [lcr_pkg::PROD_W-1:0]          prod_q;
  logic                                neg_q;
  lcr_pkg::tick_t                      s1_rec_q;
  logic [lcr_pkg::DIFF_W-1:0]          mag;
  logic [lcr_pkg::PROD_W:0]            rounded;
  logic [lcr_pkg::PROD_W-lcr_pkg::FRAC_SHIFT:0] shifted;
  logic [lcr_pkg::WEIGHT_W-1:0]        weight;
  logic                                out_adv, s1_adv;
  logic                                out_valid_q;
  lcr_pkg::out_word_t                  out_q;

  assign out_adv     = !out_valid_q || !out_stall_i;
  assign s1_adv      = !s1_valid_q || out_adv;
  assign pop_o       = rec_avail_i && s1_adv;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign mag = rec_i.diff[lcr_pkg::DIFF_W-1] ? lcr_pkg::DIFF_W'(-rec_i.diff)
                                              : lcr_pkg::DIFF_W'(rec_i.diff);

  always_comb begin
    rounded = {1'b0, prod_q} + lcr_pkg::ROUND_BIAS;
    shifted = rounded[lcr_pkg::PROD_W:lcr_pkg::FRAC_SHIFT];
    if (!s1_rec_q.weight_valid) begin
      weight = '0;
    end else if (!neg_q) begin
      weight = (shifted > (lcr_pkg::PROD_W - lcr_pkg::FRAC_SHIFT + 1)'(lcr_pkg::WEIGHT_MAX))
               ? lcr_pkg::WEIGHT_MAX : shifted[lcr_pkg::WEIGHT_W-1:0];
    end else if (shifted > (lcr_pkg::PROD_W - lcr_pkg::FRAC_SHIFT + 1)'(lcr_pkg::WEIGHT_MIN))
    begin
      weight = lcr_pkg::WEIGHT_MIN;
    end else begin
      weight = '0 - shifted[lcr_pkg::WEIGHT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      prod_q   <= lcr_pkg::PROD_W'(mag) * lcr_pkg::PROD_W'(scale_i);
      neg_q    <= rec_i.diff[lcr_pkg::DIFF_W-1];
      s1_rec_q <= rec_i;
    end
    if (out_adv && s1_valid_q) begin
      out_q.clock_pin    <= s1_rec_q.clock_pin;
      out_q.busy_res     <= s1_rec_q.busy_res;
      out_q.weight_valid <= s1_rec_q.weight_valid;
      out_q.weight_q8    <= weight;
      out_q.raw_count    <= s1_rec_q.raw_count;
      out_q.tare_count   <= s1_rec_q.tare_count;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_valid_q <= pop_o;
      end
      if (out_adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

endmodule
